[hw/rtl/i2cseq_pkg.sv]
// ----------------------------------------------------------------------------
// i2cseq_pkg: shared types and helpers for the I2C register transfer sequencer
// Event codes, phases, item/result/state records and byte-lane helpers.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  // Word geometry
  localparam int WordBits  = 32;
  localparam int ByteBits  = 8;
  localparam int WordBytes = 4;
  localparam int WordLanes = WordBits / ByteBits;

  // Largest byte count the 3-bit down counter and the word can take
  localparam int CountLimitInt = (WordBytes > 7) ? 7 : ((WordBytes < 1) ? 1 : WordBytes);
  localparam logic [2:0] CountLimit = 3'(CountLimitInt);

  localparam logic [7:0] ByteMask = 8'hFF;

  // Bus event codes
  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0,
    OP_ACK   = 3'd1,
    OP_NACK  = 3'd2,
    OP_RXBYTE = 3'd3,
    OP_STOP  = 3'd4
  } opcode_t;

  // Transaction phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_MCMD  = 3'd2,
    PH_REQ   = 3'd3,
    PH_DATA  = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  // One input event
  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  device_addr;
    logic [7:0]  register_addr;
    logic [2:0]  byte_count;
    logic        is_read;
    logic [31:0] data_word;
    logic [31:0] completion_tag;
    logic [7:0]  rx_byte;
  } item_t;

  // One result
  typedef struct packed {
    logic        issue_start;
    logic        issue_stop;
    logic        issue_ack;
    logic        issue_nack;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [31:0] word_out;
    logic        busy_flag;
    logic        done_pulse;
    logic [31:0] done_tag;
    logic        sequence_error;
  } result_t;

  // Sequencer state
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  bytes_left;
    logic [31:0] word_reg;
    logic [6:0]  target_addr;
    logic [7:0]  reg_byte;
    logic        read_mode;
    logic [31:0] tag_reg;
    logic        busy;
  } state_t;

  // Byte lane of the word, zero above the word
  function automatic logic [7:0] lane_get(input logic [31:0] word, input logic [2:0] lane);
    logic [7:0] b;
    b = 8'h00;
    if (int'(lane) < WordLanes) begin
      b = word[{lane[1:0], 3'b000} +: ByteBits];
    end
    return b;
  endfunction

  // Replace one byte lane, lanes above the word are dropped
  function automatic logic [31:0] lane_put(input logic [31:0] word, input logic [2:0] lane,
                                           input logic [7:0] b);
    logic [31:0] w;
    w = word;
    if (int'(lane) < WordLanes) begin
      w[{lane[1:0], 3'b000} +: ByteBits] = b & ByteMask;
    end
    return w;
  endfunction

endpackage

[hw/rtl/i2cseq_step.sv]
// ----------------------------------------------------------------------------
// i2cseq_step: one-event state update
// Combinational next-state and command decode for a single bus event.
// ----------------------------------------------------------------------------
module i2cseq_step (
  input  i2cseq_pkg::item_t   item,
  input  i2cseq_pkg::state_t  cur,
  output i2cseq_pkg::state_t  nxt,
  output i2cseq_pkg::result_t res
);

  logic [2:0] cnt_sat;
  logic [2:0] bl_dec;
  logic [7:0] wr_addr_byte;
  logic [7:0] rd_addr_byte;

  // Clamp the requested byte count into 1..limit
  always_comb begin
    cnt_sat = item.byte_count;
    if (cnt_sat == 3'd0) begin
      cnt_sat = 3'd1;
    end
    if (cnt_sat > i2cseq_pkg::CountLimit) begin
      cnt_sat = i2cseq_pkg::CountLimit;
    end
  end

  assign bl_dec       = cur.bytes_left - 3'd1;
  assign wr_addr_byte = {cur.target_addr, 1'b0};
  assign rd_addr_byte = {cur.target_addr, 1'b1};

  // Event decode
  always_comb begin
    nxt = cur;
    res = '0;
    case (i2cseq_pkg::opcode_t'(item.opcode))
      i2cseq_pkg::OP_BEGIN: begin
        if (cur.busy) begin
          res.sequence_error = 1'b1;
        end else begin
          nxt.target_addr = item.device_addr;
          nxt.reg_byte    = item.register_addr;
          nxt.bytes_left  = cnt_sat;
          nxt.read_mode   = item.is_read;
          nxt.word_reg    = item.data_word;
          nxt.tag_reg     = item.completion_tag;
          nxt.busy        = 1'b1;
          nxt.phase       = i2cseq_pkg::PH_START;
          res.issue_start = 1'b1;
          res.tx_valid    = 1'b1;
          res.tx_byte     = {item.device_addr, 1'b0};
        end
      end
      i2cseq_pkg::OP_ACK: begin
        if (cur.phase == i2cseq_pkg::PH_START) begin
          nxt.phase    = i2cseq_pkg::PH_MCMD;
          res.tx_valid = 1'b1;
          res.tx_byte  = cur.reg_byte;
        end else if (cur.phase == i2cseq_pkg::PH_MCMD) begin
          if (cur.read_mode) begin
            nxt.phase       = i2cseq_pkg::PH_REQ;
            res.issue_start = 1'b1;
            res.tx_valid    = 1'b1;
            res.tx_byte     = rd_addr_byte;
          end else if (cur.bytes_left != 3'd0) begin
            nxt.phase      = i2cseq_pkg::PH_DATA;
            nxt.bytes_left = bl_dec;
            res.tx_valid   = 1'b1;
            res.tx_byte    = i2cseq_pkg::lane_get(cur.word_reg, bl_dec);
          end else begin
            res.sequence_error = 1'b1;
          end
        end else if (cur.phase == i2cseq_pkg::PH_REQ) begin
          nxt.phase = i2cseq_pkg::PH_DATA;
        end else if (cur.phase == i2cseq_pkg::PH_DATA && !cur.read_mode) begin
          if (cur.bytes_left != 3'd0) begin
            nxt.bytes_left = bl_dec;
            res.tx_valid   = 1'b1;
            res.tx_byte    = i2cseq_pkg::lane_get(cur.word_reg, bl_dec);
          end else begin
            res.issue_stop = 1'b1;
            nxt.phase      = i2cseq_pkg::PH_STOP;
          end
        end else begin
          res.sequence_error = 1'b1;
        end
      end
      i2cseq_pkg::OP_NACK: begin
        // address NACK on the read phase: repeat the repeated START
        if (cur.phase == i2cseq_pkg::PH_REQ) begin
          res.issue_start = 1'b1;
          res.tx_valid    = 1'b1;
          res.tx_byte     = rd_addr_byte;
        end else begin
          res.sequence_error = 1'b1;
        end
      end
      i2cseq_pkg::OP_RXBYTE: begin
        if (cur.phase == i2cseq_pkg::PH_DATA && cur.read_mode && cur.bytes_left != 3'd0) begin
          nxt.bytes_left = bl_dec;
          nxt.word_reg   = i2cseq_pkg::lane_put(cur.word_reg, bl_dec, item.rx_byte);
          if (bl_dec != 3'd0) begin
            res.issue_ack = 1'b1;
          end else begin
            res.issue_nack = 1'b1;
            res.issue_stop = 1'b1;
            nxt.phase      = i2cseq_pkg::PH_STOP;
          end
        end else begin
          res.sequence_error = 1'b1;
        end
      end
      i2cseq_pkg::OP_STOP: begin
        if (cur.phase == i2cseq_pkg::PH_STOP) begin
          nxt.busy       = 1'b0;
          nxt.phase      = i2cseq_pkg::PH_IDLE;
          res.done_pulse = 1'b1;
          res.done_tag   = cur.tag_reg;
        end else begin
          res.sequence_error = 1'b1;
        end
      end
      default: begin
        res.sequence_error = 1'b1;
      end
    endcase
    res.word_out  = nxt.word_reg;
    res.busy_flag = nxt.busy;
  end

endmodule

[hw/rtl/i2c_master_register_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_sequencer: I2C register read/write sequencer
// Turns bus events into START/STOP/ACK/NACK and byte commands, one result each.
// ----------------------------------------------------------------------------
// Each accepted event gives exactly one result transfer. An event is captured
// in an input register, decoded against the sequencer state in one
// combinational pass, and its result lands in an output register that drives
// the master stream. The block takes one event per cycle as long as
// the result side keeps up. The rate is set by that single decode pass: the
// state update of one event feeds the decode of the next in the following
// cycle. Back-pressure on the result side holds the input register, which
// then drops s_tready.
module i2c_master_register_transfer_sequencer (
  input  logic        clk,
  input  logic        rst,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // device_addr[6:0], register_addr[14:7], byte_count[17:15], is_read[18],
  // data_word[50:19], completion_tag[82:51], rx_byte[90:83], zero fill
  input  logic [95:0] s_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // issue_start[0], issue_stop[1], issue_ack[2], issue_nack[3], tx_valid[4],
  // tx_byte[12:5], word_out[44:13], busy_flag[45], done_pulse[46],
  // done_tag[78:47], sequence_error[79]
  output logic [79:0] m_tdata
);

  logic                in_valid;
  i2cseq_pkg::item_t   in_item;
  logic                out_valid;
  i2cseq_pkg::result_t out_res;
  i2cseq_pkg::state_t  state;
  i2cseq_pkg::state_t  state_next;
  i2cseq_pkg::result_t step_res;
  logic                advance;

  // Move the held event forward when the result slot is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.opcode         <= s_tuser;
      in_item.device_addr    <= s_tdata[6:0];
      in_item.register_addr  <= s_tdata[14:7];
      in_item.byte_count     <= s_tdata[17:15];
      in_item.is_read        <= s_tdata[18];
      in_item.data_word      <= s_tdata[50:19];
      in_item.completion_tag <= s_tdata[82:51];
      in_item.rx_byte        <= s_tdata[90:83];
    end
  end

  // Event decode
  i2cseq_step u_step (
    .item (in_item),
    .cur  (state),
    .nxt  (state_next),
    .res  (step_res)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= i2cseq_pkg::PH_IDLE;
      state.bytes_left  <= 3'd0;
      state.word_reg    <= '0;
      state.target_addr <= '0;
      state.reg_byte    <= '0;
      state.read_mode   <= 1'b0;
      state.tag_reg     <= '0;
      state.busy        <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.sequence_error, out_res.done_tag, out_res.done_pulse,
                     out_res.busy_flag, out_res.word_out, out_res.tx_byte,
                     out_res.tx_valid, out_res.issue_nack, out_res.issue_ack,
                     out_res.issue_stop, out_res.issue_start};

`ifndef NO_ASSERTIONS
  // idle phase and busy always agree
  a_idle_busy: assert property (@(posedge clk) disable iff (rst)
    (state.phase == i2cseq_pkg::PH_IDLE) == !state.busy)
    else $error("phase and busy disagree");

  // a rejected event issues no bus command
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.sequence_error) |->
      !(out_res.issue_start || out_res.issue_stop || out_res.issue_ack ||
        out_res.issue_nack || out_res.tx_valid || out_res.done_pulse))
    else $error("command issued on sequence error");

  // completion leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.done_pulse) |-> !out_res.busy_flag)
    else $error("done reported while still busy");

  // ACK and NACK are never issued together
  a_ack_nack: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.issue_ack && out_res.issue_nack))
    else $error("ACK and NACK both issued");
`endif

endmodule

[sim/i2c_master_register_transfer_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_sequencer_tb: self-checking bench for the
// I2C register transfer sequencer.
// Drives bus events through the slave stream and follows each accepted event
// with its own copy of the sequencer state. Every result on the master stream
// is checked field by field against the oldest predicted command. The tests
// cover directed write, read with retry and out-of-order events, then
// state-guided random transfers with injected noise. Both streams idle at
// random.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_sequencer_tb;

  localparam int RandomItems   = 400;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;
  localparam int NoisePct      = 8;
  // Event codes the block does not define
  localparam logic [2:0] OpUndefFirst = 3'd5;
  localparam logic [2:0] OpUndefLast  = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;

  i2c_master_register_transfer_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted sequencer state
  i2cseq_pkg::phase_t ph_q;
  logic [2:0]  left_q;
  logic [31:0] word_q;
  logic [6:0]  dev_q;
  logic [7:0]  reg_q;
  logic        rd_q;
  logic [31:0] tag_q;
  logic        busy_q;

  i2cseq_pkg::result_t expected_bus_cmds[$];

  int mismatches  = 0;
  int n_events    = 0;
  int n_useful    = 0;
  int n_done      = 0;
  int n_seq_err   = 0;
  int n_results   = 0;
  int burst_left  = 0;
  int rx_cycle    = 0;
  int idle_cycles = 0;

  // Byte of the word at a lane, zero for lanes past the word
  function automatic logic [7:0] word_lane(input logic [31:0] w, input logic [2:0] lane);
    if (lane >= i2cseq_pkg::WordLanes) return 8'h00;
    return 8'(w >> (8 * lane));
  endfunction

  // Advance the predicted state by one event and give the command it causes
  task automatic sequence_bus_event(input i2cseq_pkg::item_t ev,
                                    output i2cseq_pkg::result_t r);
    logic [2:0] cnt;
    r = '0;
    cnt = ev.byte_count;
    case (ev.opcode)
      i2cseq_pkg::OP_BEGIN: begin
        if (busy_q) begin
          r.sequence_error = 1'b1;
        end else begin
          if (cnt == 3'd0) cnt = 3'd1;
          if (cnt > i2cseq_pkg::CountLimit) cnt = i2cseq_pkg::CountLimit;
          dev_q  = ev.device_addr;
          reg_q  = ev.register_addr;
          left_q = cnt;
          rd_q   = ev.is_read;
          word_q = ev.data_word;
          tag_q  = ev.completion_tag;
          busy_q = 1'b1;
          ph_q   = i2cseq_pkg::PH_START;
          r.issue_start = 1'b1;
          r.tx_valid    = 1'b1;
          r.tx_byte     = {dev_q, 1'b0};
        end
      end
      i2cseq_pkg::OP_ACK: begin
        if (ph_q == i2cseq_pkg::PH_START) begin
          ph_q = i2cseq_pkg::PH_MCMD;
          r.tx_valid = 1'b1;
          r.tx_byte  = reg_q;
        end else if (ph_q == i2cseq_pkg::PH_MCMD && rd_q) begin
          ph_q = i2cseq_pkg::PH_REQ;
          r.issue_start = 1'b1;
          r.tx_valid    = 1'b1;
          r.tx_byte     = {dev_q, 1'b1};
        end else if ((ph_q == i2cseq_pkg::PH_MCMD ||
                      (ph_q == i2cseq_pkg::PH_DATA && !rd_q)) && left_q != 3'd0) begin
          ph_q   = i2cseq_pkg::PH_DATA;
          left_q = left_q - 3'd1;
          r.tx_valid = 1'b1;
          r.tx_byte  = word_lane(word_q, left_q);
        end else if (ph_q == i2cseq_pkg::PH_REQ) begin
          ph_q = i2cseq_pkg::PH_DATA;
        end else if (ph_q == i2cseq_pkg::PH_DATA && !rd_q) begin
          // all bytes out, close the write
          ph_q = i2cseq_pkg::PH_STOP;
          r.issue_stop = 1'b1;
        end else begin
          r.sequence_error = 1'b1;
        end
      end
      i2cseq_pkg::OP_NACK: begin
        // repeated start retry while waiting for the read address ack
        if (ph_q == i2cseq_pkg::PH_REQ) begin
          r.issue_start = 1'b1;
          r.tx_valid    = 1'b1;
          r.tx_byte     = {dev_q, 1'b1};
        end else begin
          r.sequence_error = 1'b1;
        end
      end
      i2cseq_pkg::OP_RXBYTE: begin
        if (ph_q == i2cseq_pkg::PH_DATA && rd_q && left_q != 3'd0) begin
          left_q = left_q - 3'd1;
          if (left_q < i2cseq_pkg::WordLanes) word_q[8 * left_q +: 8] = ev.rx_byte;
          if (left_q != 3'd0) begin
            r.issue_ack = 1'b1;
          end else begin
            r.issue_nack = 1'b1;
            r.issue_stop = 1'b1;
            ph_q = i2cseq_pkg::PH_STOP;
          end
        end else begin
          r.sequence_error = 1'b1;
        end
      end
      i2cseq_pkg::OP_STOP: begin
        if (ph_q == i2cseq_pkg::PH_STOP) begin
          busy_q = 1'b0;
          ph_q   = i2cseq_pkg::PH_IDLE;
          r.done_pulse = 1'b1;
          r.done_tag   = tag_q;
        end else begin
          r.sequence_error = 1'b1;
        end
      end
      default: r.sequence_error = 1'b1;
    endcase
    r.word_out  = word_q;
    r.busy_flag = busy_q;
  endtask

  // Event with every field random; byte count mostly in range
  function automatic i2cseq_pkg::item_t random_event(input logic [2:0] op);
    i2cseq_pkg::item_t ev;
    ev.opcode         = op;
    ev.device_addr    = 7'($urandom);
    ev.register_addr  = 8'($urandom);
    ev.byte_count     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 4));
    ev.is_read        = 1'($urandom);
    ev.data_word      = $urandom;
    ev.completion_tag = $urandom;
    ev.rx_byte        = 8'($urandom);
    return ev;
  endfunction

  // Send one event in sender bursts, predict it on acceptance
  task automatic send_event(input i2cseq_pkg::item_t ev);
    i2cseq_pkg::result_t want;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= ev.opcode;
    s_tdata  <= {5'b0, ev.rx_byte, ev.completion_tag, ev.data_word, ev.is_read,
                 ev.byte_count, ev.register_addr, ev.device_addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sequence_bus_event(ev, want);
    expected_bus_cmds.push_back(want);
    n_events++;
    if (!want.sequence_error) n_useful++;
  endtask

  // Feed the events the current phase wants until the transfer ends
  task automatic finish_transfer(input int noise_pct);
    i2cseq_pkg::item_t ev;
    while (busy_q) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        ev = random_event(3'($urandom_range(0, 7)));
      end else begin
        case (ph_q)
          i2cseq_pkg::PH_REQ:
            ev = random_event(($urandom_range(0, 3) == 0) ? i2cseq_pkg::OP_NACK
                                                          : i2cseq_pkg::OP_ACK);
          i2cseq_pkg::PH_DATA:
            ev = random_event(rd_q ? i2cseq_pkg::OP_RXBYTE : i2cseq_pkg::OP_ACK);
          i2cseq_pkg::PH_STOP: ev = random_event(i2cseq_pkg::OP_STOP);
          default: ev = random_event(i2cseq_pkg::OP_ACK);
        endcase
      end
      send_event(ev);
    end
  endtask

  task automatic test_write_saturated_count;
    i2cseq_pkg::item_t ev;
    ev = random_event(i2cseq_pkg::OP_BEGIN);
    ev.device_addr    = 7'h7F;
    ev.register_addr  = 8'hFF;
    ev.byte_count     = 3'd7;
    ev.is_read        = 1'b0;
    ev.data_word      = 32'hFFFF_FFFF;
    ev.completion_tag = 32'hFFFF_FFFF;
    send_event(ev);
    send_event(random_event(i2cseq_pkg::OP_ACK));
    send_event(random_event(i2cseq_pkg::OP_ACK));
    // nack is only legal while retrying the read address
    send_event(random_event(i2cseq_pkg::OP_NACK));
    finish_transfer(0);
  endtask

  task automatic test_read_with_retry;
    i2cseq_pkg::item_t ev;
    ev = random_event(i2cseq_pkg::OP_BEGIN);
    ev.device_addr    = 7'h00;
    ev.register_addr  = 8'h00;
    ev.byte_count     = 3'd0;
    ev.is_read        = 1'b1;
    ev.data_word      = 32'h0;
    ev.completion_tag = 32'h0;
    send_event(ev);
    send_event(random_event(i2cseq_pkg::OP_ACK));
    send_event(random_event(i2cseq_pkg::OP_ACK));
    // begin while busy
    send_event(random_event(i2cseq_pkg::OP_BEGIN));
    send_event(random_event(i2cseq_pkg::OP_NACK));
    // data byte before the read address is acked
    send_event(random_event(i2cseq_pkg::OP_RXBYTE));
    send_event(random_event(i2cseq_pkg::OP_ACK));
    ev = random_event(i2cseq_pkg::OP_RXBYTE);
    ev.rx_byte = 8'hFF;
    send_event(ev);
    send_event(random_event(i2cseq_pkg::OP_STOP));
  endtask

  task automatic test_wrong_state_events;
    logic [2:0] op;
    send_event(random_event(i2cseq_pkg::OP_ACK));
    send_event(random_event(i2cseq_pkg::OP_NACK));
    send_event(random_event(i2cseq_pkg::OP_RXBYTE));
    send_event(random_event(i2cseq_pkg::OP_STOP));
    for (op = OpUndefFirst; op != 3'd0; op++) begin
      send_event(random_event(op));
      if (op == OpUndefLast) break;
    end
  endtask

  task automatic test_random_traffic;
    int target;
    target = n_useful + RandomItems;
    while (n_useful < target) begin
      // stray events between transfers
      if ($urandom_range(0, 6) == 0) send_event(random_event(3'($urandom_range(0, 7))));
      if (!busy_q) send_event(random_event(i2cseq_pkg::OP_BEGIN));
      finish_transfer(NoisePct);
    end
  endtask

  // Result side stalls in turn on four patterns: always ready, random, periodic and mostly ready
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 150) % 4)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom);
      2:       m_tready <= (rx_cycle % 4) == 0;
      default: m_tready <= $urandom_range(0, 4) != 0;
    endcase
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    i2cseq_pkg::result_t got;
    i2cseq_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.issue_start    = m_tdata[0];
      got.issue_stop     = m_tdata[1];
      got.issue_ack      = m_tdata[2];
      got.issue_nack     = m_tdata[3];
      got.tx_valid       = m_tdata[4];
      got.tx_byte        = m_tdata[12:5];
      got.word_out       = m_tdata[44:13];
      got.busy_flag      = m_tdata[45];
      got.done_pulse     = m_tdata[46];
      got.done_tag       = m_tdata[78:47];
      got.sequence_error = m_tdata[79];
      n_results++;
      if (expected_bus_cmds.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_bus_cmds.pop_front();
        if (want.done_pulse) n_done++;
        if (want.sequence_error) n_seq_err++;
        compare_field("issue_start", 32'(want.issue_start), 32'(got.issue_start));
        compare_field("issue_stop", 32'(want.issue_stop), 32'(got.issue_stop));
        compare_field("issue_ack", 32'(want.issue_ack), 32'(got.issue_ack));
        compare_field("issue_nack", 32'(want.issue_nack), 32'(got.issue_nack));
        compare_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
        compare_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
        compare_field("word_out", want.word_out, got.word_out);
        compare_field("busy_flag", 32'(want.busy_flag), 32'(got.busy_flag));
        compare_field("done_pulse", 32'(want.done_pulse), 32'(got.done_pulse));
        compare_field("done_tag", want.done_tag, got.done_tag);
        compare_field("sequence_error", 32'(want.sequence_error),
                      32'(got.sequence_error));
      end
    end
  end

  // Watchdog: end the run when no transfer moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               WatchdogLimit, expected_bus_cmds.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    ph_q     = i2cseq_pkg::PH_IDLE;
    left_q   = '0;
    word_q   = '0;
    dev_q    = '0;
    reg_q    = '0;
    rd_q     = 1'b0;
    tag_q    = '0;
    busy_q   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_wrong_state_events();
    test_write_saturated_count();
    test_read_with_retry();
    test_random_traffic();

    @(negedge clk) s_tvalid <= 1'b0;
    while (expected_bus_cmds.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d bus events, %0d in sequence and %0d out of sequence;", n_events,
             n_useful, n_seq_err);
    $display("checked %0d results, %0d transfers completed.", n_results, n_done);
    if (mismatches == 0 && expected_bus_cmds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
